/* hw/rtl/fcr_pkg.sv */
`default_nettype none
package fcr_pkg;

  // Ring geometry; RING_DEPTH must be a power of two (slot = count modulo depth).
  localparam int RING_DEPTH  = 64;
  localparam int FRAME_BYTES = 33;

  localparam int SLOT_W    = $clog2(RING_DEPTH);
  localparam int BYTE_AW   = $clog2(RING_DEPTH * FRAME_BYTES);
  localparam int OFS_W     = $clog2(FRAME_BYTES + 1);
  localparam int GAP_W     = 16;
  localparam logic [GAP_W-1:0] GAP_MAX = '1;

  typedef enum logic [2:0] {
    CMD_RECORD  = 3'd0,
    CMD_READ    = 3'd1,
    CMD_START   = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_FREEZE  = 3'd4,
    CMD_ANOMALY = 3'd5
  } cmd_t;

  typedef enum logic {
    RES_OK        = 1'b0,
    RES_OUT_RANGE = 1'b1
  } res_code_t;

  typedef enum logic [1:0] {
    RD_IDLE,
    RD_FETCH,
    RD_EMIT,
    RD_RANGE
  } rd_state_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  frame_byte;
    logic        frame_end;
    logic [7:0]  direction;
    logic        crc_good;
    logic [31:0] gap_micros;
    logic [31:0] time_stamp;
    logic [31:0] read_position;
  } in_item_t;

  typedef struct packed {
    logic        result_code;
    logic        armed_flag;
    logic        frozen_flag;
    logic [31:0] entries_recorded;
    logic [31:0] entry_time;
    logic [7:0]  entry_direction;
    logic        entry_crc_good;
    logic [15:0] entry_gap;
    logic [7:0]  data_byte;
    logic        last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [31:0]      stamp;
    logic [7:0]       dir;
    logic             crc;
    logic [GAP_W-1:0] gap;
  } meta_t;

  typedef struct packed {
    logic              meta_we;
    logic [SLOT_W-1:0] meta_addr;
    meta_t             meta_data;
    logic              byte_we;
    logic [BYTE_AW-1:0] byte_addr;
    logic [7:0]        byte_data;
  } wr_req_t;

  typedef struct packed {
    logic               meta_re;
    logic [SLOT_W-1:0]  meta_addr;
    logic               byte_re;
    logic [BYTE_AW-1:0] byte_addr;
  } rd_req_t;

  typedef struct packed {
    logic        armed;
    logic        frozen;
    logic [31:0] total;
  } status_t;

endpackage
`default_nettype wire

/* hw/rtl/fcr_store.sv */
`default_nettype none
module fcr_store (
  input  wire logic              clk,
  input  wire fcr_pkg::wr_req_t  wr,
  input  wire fcr_pkg::rd_req_t  rd,
  output fcr_pkg::meta_t         meta_q,
  output logic [7:0]             byte_q
);

  fcr_pkg::meta_t meta_mem [fcr_pkg::RING_DEPTH];
  logic [7:0]     byte_mem [fcr_pkg::RING_DEPTH * fcr_pkg::FRAME_BYTES];

  always_ff @(posedge clk) begin
    if (wr.meta_we) begin
      meta_mem[wr.meta_addr] <= wr.meta_data;
    end
    if (rd.meta_re) begin
      meta_q <= meta_mem[rd.meta_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr.byte_we) begin
      byte_mem[wr.byte_addr] <= wr.byte_data;
    end
    if (rd.byte_re) begin
      byte_q <= byte_mem[rd.byte_addr];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fcr_ctrl.sv */
`default_nettype none
module fcr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire fcr_pkg::in_item_t in_item,
  input  wire logic              cfg_we,
  input  wire logic              cfg_bit,
  output fcr_pkg::wr_req_t       wr,
  output fcr_pkg::status_t       status
);

  logic                        armed_r, armed_nxt;
  logic                        frozen_r, frozen_nxt;
  logic [31:0]                 total_r, total_nxt;
  logic                        inside_r, inside_nxt;
  logic                        taken_r, taken_nxt;
  logic [fcr_pkg::OFS_W-1:0]   ofs_r, ofs_nxt;
  logic [fcr_pkg::BYTE_AW-1:0] waddr_r, waddr_nxt;
  logic                        afe_r;

  logic                        first;
  logic                        take;
  logic                        taken_eff;
  logic [fcr_pkg::OFS_W-1:0]   ofs_eff;
  logic [fcr_pkg::BYTE_AW-1:0] base;
  logic                        in_room;
  logic [fcr_pkg::SLOT_W-1:0]  slot;

  assign slot    = total_r[fcr_pkg::SLOT_W-1:0];
  assign first   = !inside_r;
  assign take    = armed_r && !frozen_r;
  assign taken_eff = first ? take : taken_r;
  assign ofs_eff = first ? '0 : ofs_r;
  assign base    = first ? fcr_pkg::BYTE_AW'(fcr_pkg::BYTE_AW'(slot) *
                                             fcr_pkg::BYTE_AW'(fcr_pkg::FRAME_BYTES))
                         : waddr_r;
  assign in_room = ofs_eff < fcr_pkg::OFS_W'(fcr_pkg::FRAME_BYTES);

  always_comb begin
    armed_nxt  = armed_r;
    frozen_nxt = frozen_r;
    total_nxt  = total_r;
    inside_nxt = inside_r;
    taken_nxt  = taken_r;
    ofs_nxt    = ofs_r;
    waddr_nxt  = waddr_r;
    wr         = '0;
    wr.meta_addr            = slot;
    wr.meta_data.stamp      = in_item.time_stamp;
    wr.meta_data.dir        = in_item.direction;
    wr.meta_data.crc        = in_item.crc_good;
    wr.meta_data.gap        = (|in_item.gap_micros[31:fcr_pkg::GAP_W]) ? fcr_pkg::GAP_MAX
                            : in_item.gap_micros[fcr_pkg::GAP_W-1:0];
    wr.byte_addr            = base;
    wr.byte_data            = in_item.frame_byte;
    if (in_acc) begin
      unique case (in_item.cmd)
        fcr_pkg::CMD_RECORD: begin
          // claim a slot on the first byte of an accepted frame
          if (first && take) begin
            wr.meta_we = 1'b1;
            total_nxt  = total_r + 32'd1;
          end
          wr.byte_we = taken_eff && in_room;
          waddr_nxt  = base + fcr_pkg::BYTE_AW'(1);
          if (in_item.frame_end) begin
            inside_nxt = 1'b0;
            taken_nxt  = 1'b0;
            ofs_nxt    = '0;
          end else begin
            inside_nxt = 1'b1;
            taken_nxt  = taken_eff;
            ofs_nxt    = in_room ? ofs_eff + fcr_pkg::OFS_W'(1) : ofs_eff;
          end
        end
        fcr_pkg::CMD_START: begin
          frozen_nxt = 1'b0;
          armed_nxt  = 1'b1;
        end
        fcr_pkg::CMD_STOP:   armed_nxt = 1'b0;
        fcr_pkg::CMD_FREEZE: frozen_nxt = 1'b1;
        fcr_pkg::CMD_ANOMALY: begin
          if (armed_r && afe_r) begin
            frozen_nxt = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r  <= 1'b0;
      frozen_r <= 1'b0;
      total_r  <= '0;
      inside_r <= 1'b0;
      taken_r  <= 1'b0;
      ofs_r    <= '0;
      waddr_r  <= '0;
      afe_r    <= 1'b1;
    end else begin
      armed_r  <= armed_nxt;
      frozen_r <= frozen_nxt;
      total_r  <= total_nxt;
      inside_r <= inside_nxt;
      taken_r  <= taken_nxt;
      ofs_r    <= ofs_nxt;
      waddr_r  <= waddr_nxt;
      if (cfg_we) begin
        afe_r <= cfg_bit;
      end
    end
  end

  assign status.armed  = armed_r;
  assign status.frozen = frozen_r;
  assign status.total  = total_r;

endmodule
`default_nettype wire

/* hw/rtl/fcr_reader.sv */
`default_nettype none
module fcr_reader (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_acc,
  input  wire fcr_pkg::in_item_t in_item,
  input  wire fcr_pkg::status_t  status,
  input  wire fcr_pkg::meta_t    meta_q,
  input  wire logic [7:0]        byte_q,
  output logic                   idle,
  output fcr_pkg::rd_req_t       rd,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fcr_pkg::out_item_t     out_item
);

  fcr_pkg::rd_state_t          state_r, state_nxt;
  logic [fcr_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [fcr_pkg::BYTE_AW-1:0] raddr_r, raddr_nxt;
  logic [fcr_pkg::OFS_W-1:0]   k_r, k_nxt;

  logic                        is_read;
  logic                        full;
  logic [31:0]                 avail;
  logic                        out_range;
  logic [fcr_pkg::SLOT_W-1:0]  slot_calc;
  logic                        last_k;
  logic                        emit_pop;

  assign is_read   = in_acc && (in_item.cmd == fcr_pkg::CMD_READ);
  assign full      = status.total >= 32'(fcr_pkg::RING_DEPTH);
  assign avail     = full ? 32'(fcr_pkg::RING_DEPTH) : status.total;
  assign out_range = in_item.read_position >= avail;
  // oldest kept entry sits at the write slot once the ring has wrapped
  assign slot_calc = full ? status.total[fcr_pkg::SLOT_W-1:0] +
                            in_item.read_position[fcr_pkg::SLOT_W-1:0]
                          : in_item.read_position[fcr_pkg::SLOT_W-1:0];
  assign last_k    = k_r == fcr_pkg::OFS_W'(fcr_pkg::FRAME_BYTES - 1);
  assign emit_pop  = (state_r == fcr_pkg::RD_EMIT) && out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fcr_pkg::RD_IDLE: begin
        if (is_read) begin
          state_nxt = out_range ? fcr_pkg::RD_RANGE : fcr_pkg::RD_FETCH;
        end
      end
      fcr_pkg::RD_FETCH: state_nxt = fcr_pkg::RD_EMIT;
      fcr_pkg::RD_EMIT: begin
        if (out_ready && last_k) begin
          state_nxt = fcr_pkg::RD_IDLE;
        end
      end
      fcr_pkg::RD_RANGE: begin
        if (out_ready) begin
          state_nxt = fcr_pkg::RD_IDLE;
        end
      end
      default: state_nxt = fcr_pkg::RD_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    slot_nxt  = slot_r;
    raddr_nxt = raddr_r;
    k_nxt     = k_r;
    rd        = '0;
    rd.meta_addr = slot_r;
    rd.byte_addr = raddr_r;
    idle      = state_r == fcr_pkg::RD_IDLE;
    out_valid = (state_r == fcr_pkg::RD_EMIT) || (state_r == fcr_pkg::RD_RANGE);

    out_item.armed_flag       = status.armed;
    out_item.frozen_flag      = status.frozen;
    out_item.entries_recorded = status.total;
    if (state_r == fcr_pkg::RD_RANGE) begin
      out_item.result_code     = fcr_pkg::RES_OUT_RANGE;
      out_item.entry_time      = '0;
      out_item.entry_direction = '0;
      out_item.entry_crc_good  = 1'b0;
      out_item.entry_gap       = '0;
      out_item.data_byte       = '0;
      out_item.last_of_run     = 1'b1;
    end else begin
      out_item.result_code     = fcr_pkg::RES_OK;
      out_item.entry_time      = meta_q.stamp;
      out_item.entry_direction = meta_q.dir;
      out_item.entry_crc_good  = meta_q.crc;
      out_item.entry_gap       = meta_q.gap;
      out_item.data_byte       = byte_q;
      out_item.last_of_run     = last_k;
    end

    if (idle && is_read) begin
      slot_nxt = slot_calc;
    end
    if (state_r == fcr_pkg::RD_FETCH) begin
      rd.meta_re   = 1'b1;
      rd.byte_re   = 1'b1;
      rd.byte_addr = fcr_pkg::BYTE_AW'(fcr_pkg::BYTE_AW'(slot_r) *
                                       fcr_pkg::BYTE_AW'(fcr_pkg::FRAME_BYTES));
      raddr_nxt    = rd.byte_addr;
      k_nxt        = '0;
    end
    // advance to the next byte only when the current one is taken
    if (emit_pop && !last_k) begin
      rd.byte_re   = 1'b1;
      rd.byte_addr = raddr_r + fcr_pkg::BYTE_AW'(1);
      raddr_nxt    = rd.byte_addr;
      k_nxt        = k_r + fcr_pkg::OFS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcr_pkg::RD_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    raddr_r <= raddr_nxt;
    k_r     <= k_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/frame_capture_ring.sv */
// Record, start, stop, freeze and anomaly requests give no result.
// A read gives its first result in RD_EMIT, after RD_FETCH has read the entry memories, then
// one byte result per cycle while out_ready is high. An out-of-range read gives a single result.
// A read holds in_ready low until its last result is taken.
// Reset (synchronous, rst_n low) clears flags, frame count and framing state; the entry
// memories are not cleared and hold unknown data until written.
`default_nettype none
module frame_capture_ring (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fcr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fcr_pkg::out_item_t     out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data
);

  logic             in_acc;
  fcr_pkg::wr_req_t wr;
  fcr_pkg::rd_req_t rd;
  fcr_pkg::status_t status;
  fcr_pkg::meta_t   meta_q;
  logic [7:0]       byte_q;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;

  fcr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_acc  (in_acc),
    .in_item (in_data),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_bit (cfg_data),
    .wr      (wr),
    .status  (status)
  );

  fcr_store u_store (
    .clk    (clk),
    .wr     (wr),
    .rd     (rd),
    .meta_q (meta_q),
    .byte_q (byte_q)
  );

  fcr_reader u_reader (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_acc    (in_acc),
    .in_item   (in_data),
    .status    (status),
    .meta_q    (meta_q),
    .byte_q    (byte_q),
    .idle      (in_ready),
    .rd        (rd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_data)
  );

  a_no_request_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("request taken while a result is pending");

  a_read_blocks_next: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.cmd == fcr_pkg::CMD_READ) |=> !in_ready)
    else $error("read did not hold off the next request");

  a_count_stable_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_data.last_of_run) |=> $stable(out_data.entries_recorded))
    else $error("frame count changed during a read");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    (rd.byte_re || rd.meta_re) |-> !(wr.byte_we || wr.meta_we))
    else $error("memory write overlaps a read");

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fcr_pkg::*;

  localparam int CYCLE_LIMIT     = 2000000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int QUIET_CYCLES    = 8;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic      cfg_data  = 1'b0;

  logic        idle_on       = 1'b1;
  logic        hold_off_req  = 1'b0;
  logic        hold_off_done = 1'b0;
  int          rx_stall      = 0;
  int unsigned cycle_count   = 0;
  int          requests_sent   = 0;
  int          results_checked = 0;
  int          mismatches      = 0;

  // Ring state as the block should hold it
  logic                   ring_armed;
  logic                   ring_frozen;
  logic                   freeze_enable;
  logic [31:0]            frames_total;
  logic                   in_frame;
  logic                   frame_taken;
  int                     byte_pos;
  int                     cur_slot;
  meta_t                  slot_meta   [RING_DEPTH];
  logic [7:0]             slot_bytes  [RING_DEPTH][FRAME_BYTES];
  logic [FRAME_BYTES-1:0] slot_filled [RING_DEPTH];
  out_item_t              readout_q   [$];

  always #2 clk = ~clk;

  frame_capture_ring u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic string show_result(input out_item_t r);
    return {$sformatf("code=%0d armed=%0b frozen=%0b count=%0d ",
                      r.result_code, r.armed_flag, r.frozen_flag, r.entries_recorded),
            $sformatf("time=%h dir=%h crc=%0b gap=%h byte=%h last=%0b",
                      r.entry_time, r.entry_direction, r.entry_crc_good, r.entry_gap,
                      r.data_byte, r.last_of_run)};
  endfunction

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  function automatic logic [31:0] readable_span();
    return (frames_total < RING_DEPTH) ? frames_total : RING_DEPTH;
  endfunction

  function automatic int ring_slot(input logic [31:0] pos);
    return (frames_total - readable_span() + pos) % RING_DEPTH;
  endfunction

  function automatic void reset_ring_model();
    ring_armed    = 1'b0;
    ring_frozen   = 1'b0;
    freeze_enable = 1'b1;
    frames_total  = '0;
    in_frame      = 1'b0;
    frame_taken   = 1'b0;
    byte_pos      = 0;
    cur_slot      = 0;
    for (int s = 0; s < RING_DEPTH; s++) slot_filled[s] = '0;
  endfunction

  task automatic apply_request(input in_item_t req);
    out_item_t        r;
    int               slot;
    logic [GAP_W-1:0] gap_sat;
    case (req.cmd)
      CMD_RECORD: begin
        // accept or drop the whole frame at its first byte
        if (!in_frame) begin
          in_frame    = 1'b1;
          byte_pos    = 0;
          frame_taken = ring_armed && !ring_frozen;
          if (frame_taken) begin
            cur_slot     = frames_total % RING_DEPTH;
            frames_total = frames_total + 1;
            gap_sat      = (req.gap_micros > 32'(GAP_MAX)) ? GAP_MAX
                                                           : req.gap_micros[GAP_W-1:0];
            slot_meta[cur_slot] = '{stamp: req.time_stamp,
                                    dir:   req.direction,
                                    crc:   req.crc_good,
                                    gap:   gap_sat};
          end
        end
        if (frame_taken && byte_pos < FRAME_BYTES) begin
          slot_bytes[cur_slot][byte_pos]  = req.frame_byte;
          slot_filled[cur_slot][byte_pos] = 1'b1;
        end
        if (byte_pos < FRAME_BYTES) byte_pos++;
        if (req.frame_end) begin
          in_frame    = 1'b0;
          frame_taken = 1'b0;
          byte_pos    = 0;
        end
      end
      CMD_READ: begin
        r = '0;
        r.armed_flag       = ring_armed;
        r.frozen_flag      = ring_frozen;
        r.entries_recorded = frames_total;
        if (req.read_position >= readable_span()) begin
          r.result_code = RES_OUT_RANGE;
          r.last_of_run = 1'b1;
          readout_q.push_back(r);
        end else begin
          slot = ring_slot(req.read_position);
          r.result_code     = RES_OK;
          r.entry_time      = slot_meta[slot].stamp;
          r.entry_direction = slot_meta[slot].dir;
          r.entry_crc_good  = slot_meta[slot].crc;
          r.entry_gap       = slot_meta[slot].gap;
          for (int k = 0; k < FRAME_BYTES; k++) begin
            r.data_byte   = slot_bytes[slot][k];
            r.last_of_run = (k == FRAME_BYTES - 1);
            readout_q.push_back(r);
          end
        end
      end
      CMD_START: begin
        ring_frozen = 1'b0;
        ring_armed  = 1'b1;
      end
      CMD_STOP:    ring_armed = 1'b0;
      CMD_FREEZE:  ring_frozen = 1'b1;
      CMD_ANOMALY: if (ring_armed && freeze_enable) ring_frozen = 1'b1;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_gap();
    case ($urandom_range(0, 4))
      0:       return $urandom();
      1:       return $urandom_range(0, 65535);
      2:       return 32'(GAP_MAX) + $urandom_range(0, 1);
      3:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 100);
    endcase
  endfunction

  function automatic in_item_t make_request(input logic [2:0] op);
    in_item_t req;
    req.cmd           = op;
    req.frame_byte    = 8'($urandom());
    req.frame_end     = 1'($urandom());
    req.direction     = 8'($urandom());
    req.crc_good      = 1'($urandom());
    req.gap_micros    = pick_gap();
    req.time_stamp    = $urandom();
    req.read_position = $urandom();
    return req;
  endfunction

  task automatic send_request(input in_item_t req);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    apply_request(req);
    requests_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    send_request(make_request(op));
  endtask

  task automatic send_read(input logic [31:0] pos);
    in_item_t req;
    req = make_request(CMD_READ);
    req.read_position = pos;
    send_request(req);
  endtask

  // Only entries whose bytes were all written are read back
  task automatic send_random_read();
    logic [31:0] span;
    logic [31:0] pos;
    logic [31:0] ok_pos [$];
    span = readable_span();
    for (int p = 0; p < span; p++)
      if (&slot_filled[ring_slot(p)]) ok_pos.push_back(p);
    if (ok_pos.size() != 0 && $urandom_range(0, 4) != 0) begin
      pos = ok_pos[$urandom_range(0, ok_pos.size() - 1)];
    end else begin
      pos = ($urandom_range(0, 1) == 0) ? span + $urandom_range(0, 2) : $urandom();
      if (pos < span) pos = span;
    end
    send_read(pos);
  endtask

  task automatic send_random_control();
    case ($urandom_range(0, 4))
      0:       send_op(CMD_START);
      1:       send_op(CMD_STOP);
      2:       send_op(CMD_FREEZE);
      3:       send_op(CMD_ANOMALY);
      default: send_random_read();
    endcase
  endtask

  // head carries the metadata sampled at the first byte
  task automatic send_frame(input in_item_t head, input int len, input bit mix,
                            input bit closed);
    in_item_t req;
    for (int i = 0; i < len; i++) begin
      if (mix && i > 0 && $urandom_range(0, 15) == 0) send_random_control();
      req = (i == 0) ? head : make_request(CMD_RECORD);
      req.cmd       = CMD_RECORD;
      req.frame_end = closed && (i == len - 1);
      send_request(req);
    end
  endtask

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_freeze_enable(input logic value);
    wait_quiet();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    freeze_enable = value;
  endtask

  task automatic test_empty_ring();
    send_read(32'd0);
    send_read(32'hFFFF_FFFF);
    send_op(CMD_SPARE_LO);
    send_op(CMD_SPARE_HI);
    send_op(CMD_ANOMALY);
    send_read(32'd0);
    send_frame(make_request(CMD_RECORD), 2, 1'b0, 1'b1);
    send_op(CMD_FREEZE);
    send_op(CMD_STOP);
    send_read(32'd1);
  endtask

  task automatic test_frame_extremes();
    in_item_t head;
    send_op(CMD_START);
    head = make_request(CMD_RECORD);
    head.frame_byte = 8'hFF;
    head.direction  = 8'hFF;
    head.crc_good   = 1'b1;
    head.gap_micros = 32'hFFFF_FFFF;
    head.time_stamp = 32'hFFFF_FFFF;
    send_frame(head, FRAME_BYTES + 3, 1'b0, 1'b1);
    head = make_request(CMD_RECORD);
    head.frame_byte = 8'h00;
    head.direction  = 8'h00;
    head.crc_good   = 1'b0;
    head.gap_micros = 32'd0;
    head.time_stamp = 32'd0;
    send_frame(head, FRAME_BYTES, 1'b0, 1'b1);
    head = make_request(CMD_RECORD);
    head.gap_micros = 32'(GAP_MAX) + 1;
    send_frame(head, FRAME_BYTES, 1'b0, 1'b1);
    send_read(32'd0);
    send_read(32'd2);
    send_read(32'd3);
  endtask

  task automatic test_anomaly_enable();
    write_freeze_enable(1'b0);
    send_op(CMD_START);
    send_op(CMD_ANOMALY);
    send_read(32'd1);
    write_freeze_enable(1'b1);
    send_op(CMD_ANOMALY);
    send_read(32'hFFFF_FFFF);
    send_frame(make_request(CMD_RECORD), 2, 1'b0, 1'b1);
    send_op(CMD_START);
  endtask

  task automatic test_mid_frame_control();
    send_frame(make_request(CMD_RECORD), 2, 1'b0, 1'b0);
    send_op(CMD_STOP);
    send_frame(make_request(CMD_RECORD), 1, 1'b0, 1'b0);
    send_op(CMD_FREEZE);
    send_read(32'd0);
    send_frame(make_request(CMD_RECORD), 1, 1'b0, 1'b1);
    // frame begins while frozen: drop it even though start arrives mid-frame
    send_frame(make_request(CMD_RECORD), 1, 1'b0, 1'b0);
    send_op(CMD_START);
    send_frame(make_request(CMD_RECORD), 2, 1'b0, 1'b1);
    send_read(readable_span());
  endtask

  task automatic test_input_backpressure();
    hold_off_req <= 1'b1;
    send_read(32'd0);
    send_op(CMD_START);
    send_read(32'd1);
    send_frame(make_request(CMD_RECORD), 3, 1'b0, 1'b1);
    send_random_read();
    wait_quiet();
  endtask

  task automatic test_ring_wrap();
    int len;
    send_op(CMD_START);
    while (frames_total < RING_DEPTH + 8) begin
      len = $urandom_range(1, 3);
      if (&slot_filled[frames_total % RING_DEPTH]) begin
        // read the newest entry while its frame is still arriving
        send_frame(make_request(CMD_RECORD), 1, 1'b0, 1'b0);
        send_read(readable_span() - 1);
        send_frame(make_request(CMD_RECORD), len, 1'b0, 1'b1);
      end else begin
        send_frame(make_request(CMD_RECORD), len, 1'b0, 1'b1);
      end
      if ($urandom_range(0, 4) == 0) send_random_read();
    end
    send_random_read();
    send_read(RING_DEPTH);
  endtask

  task automatic run_random_phase(input int quota);
    int stop_at;
    int pick;
    stop_at = requests_sent + quota;
    while (requests_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 42)
        send_frame(make_request(CMD_RECORD), $urandom_range(1, 4), 1'b1, 1'b1);
      else if (pick < 50)
        send_frame(make_request(CMD_RECORD), $urandom_range(FRAME_BYTES, FRAME_BYTES + 3),
                   1'b1, 1'b1);
      else if (pick < 72) send_random_read();
      else if (pick < 82) send_op(CMD_START);
      else if (pick < 86) send_op(CMD_STOP);
      else if (pick < 89) send_op(CMD_FREEZE);
      else if (pick < 94) send_op(CMD_ANOMALY);
      else if (pick < 97)
        send_op(($urandom_range(0, 1) == 0) ? CMD_SPARE_LO : CMD_SPARE_HI);
      else send_frame(make_request(CMD_RECORD), $urandom_range(1, 3), 1'b1, 1'b0);
    end
    if (in_frame) send_frame(make_request(CMD_RECORD), 1, 1'b0, 1'b1);
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      write_freeze_enable((phase == 0) ? 1'b0 : (phase == 1) ? 1'b1 : 1'($urandom()));
      idle_on <= (phase < 3);
      run_random_phase((phase < 3) ? 35 : 30);
    end
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_off_req && !hold_off_done) begin
      hold_off_done <= 1'b1;
      rx_stall      <= HOLD_OFF_CYCLES - 1;
      out_ready     <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall  <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      rx_stall  <= $urandom_range(0, 16);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (readout_q.size() == 0) begin
        note_error($sformatf("unexpected result %s", show_result(out_data)));
      end else begin
        want = readout_q.pop_front();
        results_checked++;
        if (out_data !== want)
          note_error($sformatf("result mismatch\n  exp %s\n  got %s",
                               show_result(want), show_result(out_data)));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, readout_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    reset_ring_model();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    write_freeze_enable(1'b1);
    test_empty_ring();
    test_frame_extremes();
    test_anomaly_enable();
    test_mid_frame_control();
    test_input_backpressure();
    test_ring_wrap();
    test_random_traffic();
    wait_quiet();
    if (readout_q.size() != 0) begin
      mismatches++;
      $display("ERROR: %0d expected results never arrived", readout_q.size());
    end
    $display("Run covered %0d requests and %0d checked results; %0d frames captured",
             requests_sent, results_checked, frames_total);
    $display("Flag commands, anomaly freeze on and off, mid-frame control, wrap: %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/fcr_pkg.sv
hw/rtl/fcr_store.sv
hw/rtl/fcr_ctrl.sv
hw/rtl/fcr_reader.sv
hw/rtl/frame_capture_ring.sv
tb/tb.sv
